>>> sv/wsdr_pkg.sv
// Shared types, constants and register codes of the wheel speed deadband regulator.
package wsdr_pkg;

	localparam int SPEED_W    = 16;
	localparam int POWER_W    = 16;
	localparam int FRAC_BITS  = 14;
	localparam int GAIN_SHIFT = 10;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int LIMIT_W    = 15;
	localparam int GAIN_W     = 16;
	localparam int PROD_W     = 2 * (SPEED_W + 1);
	localparam int DIV_W      = SPEED_W + FRAC_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int QMAG_W     = 2 * GAIN_W - GAIN_SHIFT;

	// full power in Q2.14
	localparam logic signed [POWER_W-1:0] POWER_ONE = POWER_W'(1 << FRAC_BITS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd3;

	// register reset values
	localparam logic [LIMIT_W-1:0] FULL_RATE_RST = 15'd1000;
	localparam logic [LIMIT_W-1:0] MIN_RATE_RST  = 15'd100;
	localparam logic [LIMIT_W-1:0] DEADBAND_RST  = 15'd100;
	localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd1048;

	// item commands
	localparam logic CMD_SET_TARGET = 1'b0;
	localparam logic CMD_TICK       = 1'b1;

	typedef struct packed {
		logic                      cmd;
		logic signed [SPEED_W-1:0] target_value;
		logic signed [SPEED_W-1:0] measured_speed;
	} wsdr_item_t;

	typedef struct packed {
		logic signed [POWER_W-1:0] drive_power;
		logic signed [POWER_W-1:0] correction;
	} wsdr_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_LOAD,
		ST_DIV,
		ST_FINISH
	} wsdr_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic prep;
		logic div_load;
		logic finish;
	} wsdr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic div_done;
	} wsdr_stat_t;

endpackage

>>> sv/wsdr_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module wsdr_divider
	import wsdr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [DIV_W-1:0]   dividend,
	input  logic [SPEED_W-1:0] divisor,
	output logic [DIV_W-1:0]   quotient,
	output logic               done
);

	logic [SPEED_W-1:0]   rem_q;
	logic [DIV_W-1:0]     quot_q;
	logic [SPEED_W-1:0]   den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;

	logic [SPEED_W:0]     partial;
	logic [SPEED_W:0]     diff;
	logic                 ge;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		partial = {rem_q, quot_q[DIV_W-1]};
		diff    = partial - {1'b0, den_q};
		ge      = partial >= {1'b0, den_q};
	end

	// advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= '0;
			quot_q <= dividend;
			den_q  <= divisor;
		end else if (run_q) begin
			rem_q  <= ge ? diff[SPEED_W-1:0] : partial[SPEED_W-1:0];
			quot_q <= {quot_q[DIV_W-2:0], ge};
		end
	end

	assign quotient = quot_q;
	assign done     = !run_q;

endmodule

>>> sv/wsdr_datapath.sv
// Datapath: configuration registers, power state, shared multiplier, divider and result word.
module wsdr_datapath
	import wsdr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  wsdr_item_t           item,
	input  wsdr_cmd_t            cmd,
	output wsdr_stat_t           stat,
	output wsdr_result_t         result
);

	logic [LIMIT_W-1:0] top_q;
	logic [LIMIT_W-1:0] min_q;
	logic [LIMIT_W-1:0] dead_q;
	logic [GAIN_W-1:0]  gain_q;

	logic signed [POWER_W-1:0] drive_q;
	logic signed [SPEED_W-1:0] target_q;
	wsdr_item_t                item_q;
	wsdr_result_t              result_q;

	logic signed [PROD_W-1:0]  prod_q;
	logic                      skip_q;
	logic                      neg_q;
	logic [SPEED_W-1:0]        den_q;

	logic signed [SPEED_W:0]   v_ext;
	logic signed [SPEED_W:0]   t_ext;
	logic signed [SPEED_W:0]   err;
	logic [SPEED_W:0]          abs_v;
	logic [SPEED_W:0]          abs_t;
	logic [SPEED_W:0]          abs_err;
	logic                      use_ratio;
	logic signed [SPEED_W:0]   mul_a;
	logic signed [SPEED_W:0]   mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  seed;

	logic [PROD_W-1:0]         abs_prod;
	logic [DIV_W-1:0]          quot;
	logic                      div_done;

	logic [POWER_W-1:0]        set_mag;
	logic signed [POWER_W-1:0] set_power;
	logic [QMAG_W-1:0]         corr_raw;
	logic [POWER_W-1:0]        corr_mag;
	logic signed [POWER_W-1:0] corr;
	logic signed [POWER_W:0]   sum;
	logic signed [POWER_W-1:0] tick_power;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= FULL_RATE_RST;
			min_q  <= MIN_RATE_RST;
			dead_q <= DEADBAND_RST;
			gain_q <= GAIN_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_FULL_RATE: top_q  <= cfg_data[LIMIT_W-1:0];
				REG_MIN_RATE:  min_q  <= cfg_data[LIMIT_W-1:0];
				REG_DEADBAND:  dead_q <= cfg_data[LIMIT_W-1:0];
				REG_GAIN:      gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// hold the accepted word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	// operand magnitudes, tests and the shared multiplier
	always_comb begin
		v_ext     = {item_q.target_value[SPEED_W-1], item_q.target_value};
		t_ext     = {target_q[SPEED_W-1], target_q};
		err       = t_ext - {item_q.measured_speed[SPEED_W-1], item_q.measured_speed};
		abs_v     = v_ext[SPEED_W] ? -v_ext : v_ext;
		abs_t     = t_ext[SPEED_W] ? -t_ext : t_ext;
		abs_err   = err[SPEED_W] ? -err : err;
		use_ratio = (target_q != '0) && (drive_q != '0);
		if (item_q.cmd == CMD_TICK) begin
			mul_a = {1'b0, abs_err[SPEED_W-1:0]};
			mul_b = (SPEED_W + 1)'({1'b0, gain_q});
		end else begin
			mul_a = (SPEED_W + 1)'(drive_q);
			mul_b = v_ext;
		end
		prod = mul_a * mul_b;
		seed = PROD_W'(v_ext) <<< FRAC_BITS;
	end

	// register product, sign, divisor and zero cases
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			if (item_q.cmd == CMD_TICK) begin
				prod_q <= prod;
				neg_q  <= err[SPEED_W];
				skip_q <= (abs_t < (SPEED_W + 1)'(min_q)) ||
					(abs_err < (SPEED_W + 1)'(dead_q));
				den_q  <= '0;
			end else if (use_ratio) begin
				prod_q <= prod;
				neg_q  <= prod[PROD_W-1] ^ target_q[SPEED_W-1];
				skip_q <= abs_v < (SPEED_W + 1)'(min_q);
				den_q  <= abs_t[SPEED_W-1:0];
			end else begin
				prod_q <= seed;
				neg_q  <= seed[PROD_W-1];
				skip_q <= abs_v < (SPEED_W + 1)'(min_q);
				den_q  <= (top_q == '0) ? SPEED_W'(1) : SPEED_W'(top_q);
			end
		end
	end

	assign abs_prod = prod_q[PROD_W-1] ? -prod_q : prod_q;

	wsdr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.div_load),
		.dividend (abs_prod[DIV_W-1:0]),
		.divisor  (den_q),
		.quotient (quot),
		.done     (div_done)
	);

	// saturate the reseed and the correction, then clamp the new power
	always_comb begin
		set_mag   = (quot > DIV_W'(POWER_ONE)) ? POWER_ONE : quot[POWER_W-1:0];
		set_power = skip_q ? '0 : (neg_q ? -set_mag : set_mag);

		corr_raw  = prod_q[GAIN_SHIFT +: QMAG_W];
		corr_mag  = (corr_raw > QMAG_W'(POWER_ONE)) ? POWER_ONE : corr_raw[POWER_W-1:0];
		corr      = skip_q ? '0 : (neg_q ? -corr_mag : corr_mag);
		sum       = {drive_q[POWER_W-1], drive_q} + {corr[POWER_W-1], corr};
		if (sum > (POWER_W + 1)'(POWER_ONE)) begin
			tick_power = POWER_ONE;
		end else if (sum < -(POWER_W + 1)'(POWER_ONE)) begin
			tick_power = -POWER_ONE;
		end else begin
			tick_power = sum[POWER_W-1:0];
		end
	end

	// update power state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q  <= '0;
			target_q <= '0;
		end else if (cmd.finish) begin
			if (item_q.cmd == CMD_TICK) begin
				drive_q <= tick_power;
			end else begin
				drive_q  <= set_power;
				target_q <= item_q.target_value;
			end
		end
	end

	// load the result word
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (item_q.cmd == CMD_TICK) begin
				result_q.drive_power <= tick_power;
				result_q.correction  <= corr;
			end else begin
				result_q.drive_power <= set_power;
				result_q.correction  <= '0;
			end
		end
	end

	assign stat.is_tick  = (item_q.cmd == CMD_TICK);
	assign stat.div_done = div_done;
	assign result        = result_q;

endmodule

>>> sv/wsdr_ctrl.sv
// Controller: sequences one word through multiply, divide (set-target words only) and finish, and owns result valid.
module wsdr_ctrl
	import wsdr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	output logic       result_valid,
	input  logic       result_stall,
	input  wsdr_stat_t stat,
	output wsdr_cmd_t  cmd
);

	wsdr_state_t state_q;
	wsdr_state_t state_d;
	logic        valid_q;
	logic        out_free;

	assign out_free = !valid_q || !result_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (item_valid) state_d = ST_PREP;
			ST_PREP:     state_d = stat.is_tick ? ST_FINISH : ST_DIV_LOAD;
			ST_DIV_LOAD: state_d = ST_DIV;
			ST_DIV:      if (stat.div_done) state_d = ST_FINISH;
			ST_FINISH:   if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		item_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				cmd.load   = item_valid;
			end
			ST_PREP:     cmd.prep     = 1'b1;
			ST_DIV_LOAD: cmd.div_load = 1'b1;
			ST_FINISH:   cmd.finish   = out_free;
			default: ;
		endcase
	end

	// advance state and hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;

endmodule

>>> sv/wheel_speed_deadband_regulator.sv
// Wheel speed regulator with deadband: top level joining controller and datapath.
//
// One word in gives one word out. A tick word (cmd = 1) goes from acceptance
// to the result register through operand setup and the 17x17 multiplier,
// then correction, saturation and power clamp. A set-target word (cmd = 0)
// passes setup, divider load, the divide state (30 steps of the restoring
// divider, one bit per cycle, that forms the rescaled or seeded power, and a
// wait until the divider shows done) and the finish state. One word is in
// work at a time; item_stall stays high from acceptance until the result has
// been written to the output register, and a new word is taken while that
// result still waits downstream.
// Registers (index): 0 full-power speed, 1 minimum target speed, 2 deadband,
// 3 gain; write them only while the block is idle. Power is Q2.14,
// 16384 = full forward.
module wheel_speed_deadband_regulator
	import wsdr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  wsdr_item_t           item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output wsdr_result_t         result
);

	wsdr_cmd_t  cmd;
	wsdr_stat_t stat;

	wsdr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	wsdr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule
